// ===== hdl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    // Width of the timer and result fields.
    localparam int FIELD_BITS   = 20;
    // Width of the echo width counter; its ceiling is also held to FIELD_BITS.
    localparam int COUNTER_BITS = 20;

    localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

    localparam logic [FIELD_BITS-1:0] WIDTH_LIMIT =
        (COUNTER_BITS >= FIELD_BITS) ? FIELD_MAX
                                     : FIELD_BITS'((64'd1 << COUNTER_BITS) - 64'd1);

    // floor(w * 16 / 29) == (w * DIST_MULT) >> DIST_SHIFT for every w below 2^20.
    // DIST_MULT is ceil(2^29 / 29); the 16 is folded into the shift.
    localparam int DIST_SHIFT   = 25;
    localparam int DIST_MULT_W  = 25;
    localparam int DIST_PROD_W  = FIELD_BITS + DIST_MULT_W;
    localparam logic [DIST_MULT_W-1:0] DIST_MULT = 25'd18512791;

    // Register map, selected by paddr[2].
    localparam int  ADDR_BITS   = 3;
    localparam logic REG_TRIGGER = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [7:0]            TRIGGER_RESET = 8'd15;
    localparam logic [FIELD_BITS-1:0] TIMEOUT_RESET = 20'd200000;

    // Ranging phase, one-hot.
    typedef enum logic [1:0] {
        PH_TRIGGER = 2'b01,
        PH_WAIT    = 2'b10
    } phase_t;

    typedef struct packed {
        logic [7:0]            trigger_ticks;
        logic [FIELD_BITS-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic                  trigger_level;
        logic                  measure_done;
        logic                  timed_out;
        logic [FIELD_BITS-1:0] pulse_width;
        logic [FIELD_BITS-1:0] distance_q4;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/uer_regs.sv =====
// ----------------------------------------------------------------------------
// uer_regs
// APB-style configuration registers: trigger length and echo timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [uer_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output uer_pkg::cfg_t                      cfg
);

    logic [7:0]                      trigger_reg;
    logic [uer_pkg::FIELD_BITS-1:0]  timeout_reg;
    logic                            wr_en;
    logic                            reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    // Registers are word aligned; the byte offset within a word is ignored.
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg <= uer_pkg::TRIGGER_RESET;
            timeout_reg <= uer_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                uer_pkg::REG_TRIGGER: trigger_reg <= pwdata[7:0];
                uer_pkg::REG_TIMEOUT: timeout_reg <= pwdata[uer_pkg::FIELD_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            uer_pkg::REG_TRIGGER: prdata = 32'(trigger_reg);
            uer_pkg::REG_TIMEOUT: prdata = 32'(timeout_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.trigger_ticks = trigger_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

`default_nettype wire

// ===== hdl/uer_ranger.sv =====
// ----------------------------------------------------------------------------
// uer_ranger
// Ranging state machine: trigger pulse, echo edge detection, width count,
// timeout and distance scaling for one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ranger (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          echo,
    input  wire uer_pkg::cfg_t cfg,
    output uer_pkg::result_t   result
);

    localparam int FB = uer_pkg::FIELD_BITS;

    uer_pkg::phase_t phase_reg, phase_next;
    logic [FB-1:0]   timer_reg, timer_next;
    logic            rise_reg, rise_next;
    logic [FB-1:0]   width_reg, width_next;
    logic            prev_echo_reg;

    logic [7:0]                        trig_len;
    logic [FB-1:0]                     timer_inc;
    logic                              done;
    logic                              tout;
    logic [uer_pkg::DIST_PROD_W-1:0]   dist_prod;

    assign trig_len  = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
    assign timer_inc = timer_reg + FB'(1);

    // Constant reciprocal multiply; the width is taken straight from its register.
    assign dist_prod = uer_pkg::DIST_PROD_W'(width_reg)
                     * uer_pkg::DIST_PROD_W'(uer_pkg::DIST_MULT);

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        rise_next  = rise_reg;
        width_next = width_reg;
        done       = 1'b0;
        tout       = 1'b0;
        result     = '0;

        case (phase_reg)
            uer_pkg::PH_TRIGGER:
            begin
                result.trigger_level = 1'b1;
                if (timer_inc >= FB'(trig_len))
                begin
                    phase_next = uer_pkg::PH_WAIT;
                    timer_next = '0;
                    rise_next  = 1'b0;
                    width_next = '0;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end

            uer_pkg::PH_WAIT:
            begin
                if (timer_reg != uer_pkg::FIELD_MAX)
                begin
                    timer_next = timer_inc;
                end

                if (!rise_reg)
                begin
                    if (echo && !prev_echo_reg)
                    begin
                        rise_next  = 1'b1;
                        width_next = FB'(1);
                    end
                end
                else if (echo)
                begin
                    if (width_reg < uer_pkg::WIDTH_LIMIT)
                    begin
                        width_next = width_reg + FB'(1);
                    end
                end
                else
                begin
                    done = 1'b1;
                end

                // A completed pulse takes precedence over the timeout.
                tout = !done && (timer_reg >= cfg.timeout_ticks);

                if (done || tout)
                begin
                    phase_next = uer_pkg::PH_TRIGGER;
                    timer_next = '0;
                    rise_next  = 1'b0;
                    width_next = '0;
                end

                result.measure_done = done;
                result.timed_out    = tout;
                if (done)
                begin
                    result.pulse_width = width_reg;
                    result.distance_q4 = dist_prod[uer_pkg::DIST_SHIFT +: FB];
                end
            end

            default:
            begin
                phase_next = uer_pkg::PH_TRIGGER;
                timer_next = '0;
                rise_next  = 1'b0;
                width_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= uer_pkg::PH_TRIGGER;
            timer_reg     <= '0;
            rise_reg      <= 1'b0;
            width_reg     <= '0;
            prev_echo_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            rise_reg      <= rise_next;
            width_reg     <= width_next;
            prev_echo_reg <= echo;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Ultrasonic ranging cycle driven by a stream of 1 us echo samples.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  s_axis    in         tdata[0] echo_level (bits 7:1 unused)
//  m_axis    out        tdata: trigger_level, pulse_width, distance_q4
//                       tuser: measure_done, timed_out
//  APB       in/out     reg 0 trigger_ticks at 0x0, reg 1 timeout_ticks at 0x4
//
//  Every input item yields exactly one result item, one item per cycle while m_axis does not stall.
//  An accepted item is held in the input register and then moves into the result
//  register, from which its result is offered on m_axis.
//  The ranging state advances only when an item moves from the input register
//  into the result register; a stalled output simply holds both stages.
//  Reset (rst_n, asynchronous, active low) returns the block to the start of a
//  trigger pulse with the register defaults; no clearing pass is needed.
//
`default_nettype none

module ultrasonic_echo_ranger_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Echo sample stream.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [0] echo_level

    // Result stream.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [47:0]                        m_axis_tdata,   // [0] trigger_level,
                                                               // [20:1] pulse_width,
                                                               // [40:21] distance_q4
    output logic [1:0]                         m_axis_tuser,   // [0] measure_done,
                                                               // [1] timed_out

    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [uer_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    uer_pkg::cfg_t    cfg;
    uer_pkg::result_t result;

    // Input register: one echo sample waiting to be processed.
    logic             in_valid_reg;
    logic             echo_reg;

    // Result register.
    logic             out_valid_reg;
    uer_pkg::result_t out_reg;

    logic             advance;

    // The held sample is processed whenever the result register is free or
    // is being emptied in this same cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    uer_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_ranger u_ranger (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .echo   (echo_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            echo_reg <= s_axis_tdata[0];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.distance_q4, out_reg.pulse_width,
                            out_reg.trigger_level};
    assign m_axis_tuser  = {out_reg.timed_out, out_reg.measure_done};

endmodule

`default_nettype wire
